@@ hdl/cmft_pkg.sv @@
// Shared types and constants of the motor feedback table.
// No dependencies; used by every module of the block.
package cmft_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_FRAME     = 2'd0,
    OP_READ_SLOT = 2'd1,
    OP_READ_LAST = 2'd2
  } op_e;

  // Commands handed from the front end to the back end
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_STORE,
    CMD_READ_SLOT,
    CMD_READ_LAST
  } cmd_kind_e;

  localparam int unsigned SLOT_W    = 4;
  localparam int unsigned ID_W      = 11;
  localparam int unsigned LEN_W     = 4;
  localparam int unsigned RECORD_W  = 56;

  localparam logic [ID_W-1:0]  FIRST_ACCEPTED_ID = 11'h205;
  localparam logic [ID_W-1:0]  SLOT_ID_BASE      = 11'h204;
  localparam logic [LEN_W-1:0] MIN_FRAME_BYTES   = 4'd7;

  typedef struct packed {
    cmd_kind_e             kind;
    logic [SLOT_W-1:0]     slot;
    logic [RECORD_W-1:0]   data;
  } cmd_t;

endpackage

@@ hdl/can_motor_feedback_table_unit.sv @@
// Motor feedback table: top level with front end, command queue, back end.
// Depends on cmft_pkg, cmft_front, cmft_queue and cmft_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one word per cycle while
//   in_stall_o is low: a received CAN frame (stored in its driver slot if
//   accepted), a read of a slot entry, or a read of the last stored record.
//   Output channel (out_valid_o / out_stall_i) gives exactly one result word
//   per input word, in order. found_o low means every other field is zero.
//   Result path: an accepted word is registered in a queue entry, then in
//   the result register, where out_valid_o rises.
//   Throughput: one word per cycle while out_stall_i is low, set by the table
//   access in the back end; the two-entry queue lets the input side keep
//   running for two words while the output is stalled.
//   While out_stall_i is high the result word holds, the queue fills and
//   in_stall_o rises once it is full.
//   Reset clears slot valid marks, the last-record mark and all handshake
//   state; the block accepts words as soon as reset is released.
module can_motor_feedback_table_unit #(
  parameter int unsigned DRIVER_SLOTS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    operation_i,
  input  logic                          is_extended_i,
  input  logic                          is_remote_i,
  input  logic [cmft_pkg::LEN_W-1:0]    frame_length_i,
  input  logic [cmft_pkg::ID_W-1:0]     std_id_i,
  input  logic [cmft_pkg::RECORD_W-1:0] payload_i,
  input  logic [cmft_pkg::SLOT_W-1:0]   query_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          found_o,
  output logic [cmft_pkg::SLOT_W-1:0]   slot_o,
  output logic [15:0]                   angle_o,
  output logic signed [15:0]            speed_o,
  output logic signed [15:0]            current_o,
  output logic [7:0]                    temperature_o,
  output logic [cmft_pkg::ID_W-1:0]     source_id_o
);

  cmft_pkg::cmd_t front_cmd;
  cmft_pkg::cmd_t head_cmd;
  logic           q_full;
  logic           q_valid;
  logic           q_pop;
  logic           q_push;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  // Classify incoming words
  cmft_front #(
    .DRIVER_SLOTS (DRIVER_SLOTS)
  ) u_front (
    .operation_i    (operation_i),
    .is_extended_i  (is_extended_i),
    .is_remote_i    (is_remote_i),
    .frame_length_i (frame_length_i),
    .std_id_i       (std_id_i),
    .payload_i      (payload_i),
    .query_slot_i   (query_slot_i),
    .cmd_o          (front_cmd)
  );

  // Decoupling queue
  cmft_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (front_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (head_cmd)
  );

  // Table and result register
  cmft_back #(
    .DRIVER_SLOTS (DRIVER_SLOTS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (q_valid),
    .cmd_i         (head_cmd),
    .pop_o         (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .found_o       (found_o),
    .slot_o        (slot_o),
    .angle_o       (angle_o),
    .speed_o       (speed_o),
    .current_o     (current_o),
    .temperature_o (temperature_o),
    .source_id_o   (source_id_o)
  );

`ifndef SYNTHESIS
  // A found record always lies in a legal driver slot
  a_found_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (slot_o != '0)
      && ({1'b0, slot_o} < (cmft_pkg::SLOT_W + 1)'(DRIVER_SLOTS)))
    else $error("found result with illegal slot");

  // Not-found results carry all-zero fields
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (slot_o == '0) && (angle_o == '0) && (speed_o == '0)
      && (current_o == '0) && (temperature_o == '0) && (source_id_o == '0))
    else $error("not-found result with nonzero fields");

  // Source identifier tracks the slot
  a_source_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |->
      source_id_o == ({{(cmft_pkg::ID_W - cmft_pkg::SLOT_W){1'b0}}, slot_o}
                      + cmft_pkg::SLOT_ID_BASE))
    else $error("source id does not match slot");
`endif

endmodule

@@ hdl/cmft_front.sv @@
// Front end: classifies an incoming word into a table command.
// Depends on cmft_pkg.
module cmft_front #(
  parameter int unsigned DRIVER_SLOTS = 8
) (
  input  logic [1:0]                     operation_i,
  input  logic                           is_extended_i,
  input  logic                           is_remote_i,
  input  logic [cmft_pkg::LEN_W-1:0]     frame_length_i,
  input  logic [cmft_pkg::ID_W-1:0]      std_id_i,
  input  logic [cmft_pkg::RECORD_W-1:0]  payload_i,
  input  logic [cmft_pkg::SLOT_W-1:0]    query_slot_i,
  output cmft_pkg::cmd_t                 cmd_o
);

  logic [cmft_pkg::ID_W-1:0] id_slot;
  logic                      frame_ok;
  logic                      query_ok;

  // Slot derived from the identifier, range checks for frames and queries
  assign id_slot  = std_id_i - cmft_pkg::SLOT_ID_BASE;
  assign frame_ok = !is_extended_i && !is_remote_i
                    && (frame_length_i >= cmft_pkg::MIN_FRAME_BYTES)
                    && (std_id_i >= cmft_pkg::FIRST_ACCEPTED_ID)
                    && (id_slot < cmft_pkg::ID_W'(DRIVER_SLOTS));
  assign query_ok = (query_slot_i != '0)
                    && ({1'b0, query_slot_i} < (cmft_pkg::SLOT_W + 1)'(DRIVER_SLOTS));

  // Command build
  always_comb begin
    cmd_o      = '0;
    cmd_o.kind = cmft_pkg::CMD_NONE;
    cmd_o.data = payload_i;
    case (operation_i)
      cmft_pkg::OP_FRAME: begin
        if (frame_ok) begin
          cmd_o.kind = cmft_pkg::CMD_STORE;
          cmd_o.slot = id_slot[cmft_pkg::SLOT_W-1:0];
        end
      end
      cmft_pkg::OP_READ_SLOT: begin
        if (query_ok) begin
          cmd_o.kind = cmft_pkg::CMD_READ_SLOT;
          cmd_o.slot = query_slot_i;
        end
      end
      cmft_pkg::OP_READ_LAST: begin
        cmd_o.kind = cmft_pkg::CMD_READ_LAST;
      end
      default: begin
        cmd_o.kind = cmft_pkg::CMD_NONE;
      end
    endcase
  end

endmodule

@@ hdl/cmft_queue.sv @@
// Two-entry command queue between front end and back end.
// Depends on cmft_pkg.
module cmft_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cmft_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cmft_pkg::cmd_t head_o
);

  localparam int unsigned DEPTH = 2;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmft_pkg::cmd_t   entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = entry_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Entry storage, no reset
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ hdl/cmft_back.sv @@
// Back end: slot table, last record and the registered result word.
// Depends on cmft_pkg.
module cmft_back #(
  parameter int unsigned DRIVER_SLOTS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  cmft_pkg::cmd_t              cmd_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [cmft_pkg::SLOT_W-1:0] slot_o,
  output logic [15:0]                 angle_o,
  output logic signed [15:0]          speed_o,
  output logic signed [15:0]          current_o,
  output logic [7:0]                  temperature_o,
  output logic [cmft_pkg::ID_W-1:0]   source_id_o
);

  localparam int unsigned IDX_W = (DRIVER_SLOTS > 1) ? $clog2(DRIVER_SLOTS) : 1;

  logic [cmft_pkg::RECORD_W-1:0] record_q [DRIVER_SLOTS];
  logic [DRIVER_SLOTS-1:0]       slot_valid_q;
  logic [cmft_pkg::RECORD_W-1:0] last_record_q;
  logic [cmft_pkg::SLOT_W-1:0]   last_slot_q;
  logic                          last_valid_q;
  logic                          out_valid_q;

  logic [IDX_W-1:0]              idx;
  logic                          hit;
  logic [cmft_pkg::SLOT_W-1:0]   res_slot;
  logic [cmft_pkg::RECORD_W-1:0] res_rec;
  logic                          do_store;

  assign idx         = cmd_i.slot[IDX_W-1:0];
  assign pop_o       = cmd_valid_i && (!out_valid_q || !out_stall_i);
  assign do_store    = pop_o && (cmd_i.kind == cmft_pkg::CMD_STORE);
  assign out_valid_o = out_valid_q;

  // Execute one command against the table
  always_comb begin
    hit      = 1'b0;
    res_slot = cmd_i.slot;
    res_rec  = cmd_i.data;
    case (cmd_i.kind)
      cmft_pkg::CMD_STORE: begin
        hit = 1'b1;
      end
      cmft_pkg::CMD_READ_SLOT: begin
        hit     = slot_valid_q[idx];
        res_rec = record_q[idx];
      end
      cmft_pkg::CMD_READ_LAST: begin
        hit      = last_valid_q;
        res_slot = last_slot_q;
        res_rec  = last_record_q;
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // Control state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_valid_q <= '0;
      last_slot_q  <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (do_store) begin
        slot_valid_q[idx] <= 1'b1;
        last_slot_q       <= cmd_i.slot;
        last_valid_q      <= 1'b1;
      end
      if (pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Record storage and result payload; zeros when not found
  always_ff @(posedge clk_i) begin
    if (do_store) begin
      record_q[idx] <= cmd_i.data;
      last_record_q <= cmd_i.data;
    end
    if (pop_o) begin
      found_o       <= hit;
      slot_o        <= hit ? res_slot : '0;
      angle_o       <= hit ? res_rec[55:40] : '0;
      speed_o       <= hit ? res_rec[39:24] : '0;
      current_o     <= hit ? res_rec[23:8] : '0;
      temperature_o <= hit ? res_rec[7:0] : '0;
      source_id_o   <= hit ? ({{(cmft_pkg::ID_W - cmft_pkg::SLOT_W){1'b0}}, res_slot}
                              + cmft_pkg::SLOT_ID_BASE) : '0;
    end
  end

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for can_motor_feedback_table_unit.
// Needs cmft_pkg and the unit; a behavioral table model predicts every result word.
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned SLOTS      = 8;
  localparam int unsigned N_RANDOM   = 800;
  localparam int unsigned MAX_CYCLES = 200000;
  localparam int unsigned LONG_HOLD  = 80;
  localparam logic [1:0]  OP_UNUSED  = 2'd3;

  // One input word
  typedef struct {
    logic [1:0]                    op;
    logic                          extended;
    logic                          remote;
    logic [cmft_pkg::LEN_W-1:0]    len;
    logic [cmft_pkg::ID_W-1:0]     std_id;
    logic [cmft_pkg::RECORD_W-1:0] data;
    logic [cmft_pkg::SLOT_W-1:0]   qslot;
  } can_word_t;

  // One result word
  typedef struct {
    logic                        found;
    logic [cmft_pkg::SLOT_W-1:0] slot;
    logic [15:0]                 angle;
    logic signed [15:0]          speed;
    logic signed [15:0]          current;
    logic [7:0]                  temperature;
    logic [cmft_pkg::ID_W-1:0]   source_id;
  } feedback_t;

  logic                          clk_i;
  logic                          rst_ni          = 1'b0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [1:0]                    operation_i     = '0;
  logic                          is_extended_i   = 1'b0;
  logic                          is_remote_i     = 1'b0;
  logic [cmft_pkg::LEN_W-1:0]    frame_length_i  = '0;
  logic [cmft_pkg::ID_W-1:0]     std_id_i        = '0;
  logic [cmft_pkg::RECORD_W-1:0] payload_i       = '0;
  logic [cmft_pkg::SLOT_W-1:0]   query_slot_i    = '0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic                          found_o;
  logic [cmft_pkg::SLOT_W-1:0]   slot_o;
  logic [15:0]                   angle_o;
  logic signed [15:0]            speed_o;
  logic signed [15:0]            current_o;
  logic [7:0]                    temperature_o;
  logic [cmft_pkg::ID_W-1:0]     source_id_o;

  can_motor_feedback_table_unit #(.DRIVER_SLOTS(SLOTS)) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .is_extended_i  (is_extended_i),
    .is_remote_i    (is_remote_i),
    .frame_length_i (frame_length_i),
    .std_id_i       (std_id_i),
    .payload_i      (payload_i),
    .query_slot_i   (query_slot_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_o        (found_o),
    .slot_o         (slot_o),
    .angle_o        (angle_o),
    .speed_o        (speed_o),
    .current_o      (current_o),
    .temperature_o  (temperature_o),
    .source_id_o    (source_id_o)
  );

  // Shadow copy of the feedback table
  logic [cmft_pkg::RECORD_W-1:0] rec_store [SLOTS];
  bit                            rec_marked [SLOTS];
  logic [cmft_pkg::RECORD_W-1:0] last_rec     = '0;
  logic [cmft_pkg::SLOT_W-1:0]   last_slot_no = '0;
  bit                            last_marked  = 1'b0;

  can_word_t pending_words[$];
  feedback_t expected_feedback[$];
  can_word_t cur_word;

  int unsigned total_words   = 0;
  int unsigned words_in      = 0;
  int unsigned results_seen  = 0;
  int unsigned found_seen    = 0;
  int unsigned failures      = 0;
  int unsigned cycles        = 0;
  int unsigned gap_left      = 0;
  int unsigned hold_left     = 0;
  bit          long_hold_done = 1'b0;
  bit          quiet;

  // No idling in the final stretch, and none in every third block of 128 words
  assign quiet = (words_in + 120 >= total_words) || ((words_in / 128) % 3 == 1);

  function automatic feedback_t decode_record(logic [cmft_pkg::SLOT_W-1:0] s,
                                              logic [cmft_pkg::RECORD_W-1:0] rec);
    feedback_t r;
    r.found       = 1'b1;
    r.slot        = s;
    r.angle       = rec[55:40];
    r.speed       = rec[39:24];
    r.current     = rec[23:8];
    r.temperature = rec[7:0];
    r.source_id   = cmft_pkg::ID_W'(s) + cmft_pkg::SLOT_ID_BASE;
    return r;
  endfunction

  // Applies one accepted word to the shadow table and returns its result
  function automatic feedback_t predict_feedback(can_word_t w);
    feedback_t                 r;
    logic [cmft_pkg::ID_W-1:0] s;
    r = '{default: '0};
    case (w.op)
      cmft_pkg::OP_FRAME: begin
        s = w.std_id - cmft_pkg::SLOT_ID_BASE;
        if (!w.extended && !w.remote && w.len >= cmft_pkg::MIN_FRAME_BYTES &&
            w.std_id >= cmft_pkg::FIRST_ACCEPTED_ID && s != 0 && s < SLOTS) begin
          rec_store[s]  = w.data;
          rec_marked[s] = 1'b1;
          last_rec      = w.data;
          last_slot_no  = cmft_pkg::SLOT_W'(s);
          last_marked   = 1'b1;
          r = decode_record(cmft_pkg::SLOT_W'(s), w.data);
        end
      end
      cmft_pkg::OP_READ_SLOT: begin
        if (w.qslot != 0 && w.qslot < SLOTS && rec_marked[w.qslot])
          r = decode_record(w.qslot, rec_store[w.qslot]);
      end
      cmft_pkg::OP_READ_LAST: begin
        if (last_marked) r = decode_record(last_slot_no, last_rec);
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic can_word_t mk_word(logic [1:0] op, logic ext, logic rtr,
                                        logic [cmft_pkg::LEN_W-1:0] len,
                                        logic [cmft_pkg::ID_W-1:0] id,
                                        logic [cmft_pkg::RECORD_W-1:0] data,
                                        logic [cmft_pkg::SLOT_W-1:0] q);
    can_word_t w;
    w.op = op; w.extended = ext; w.remote = rtr; w.len = len;
    w.std_id = id; w.data = data; w.qslot = q;
    return w;
  endfunction

  // Random mix of well-formed frames and reads; some broken frames and noise
  function automatic can_word_t random_word();
    can_word_t   w;
    int unsigned pick;
    w = mk_word(2'($urandom_range(0, 3)), 1'($urandom), 1'($urandom),
                cmft_pkg::LEN_W'($urandom_range(0, 15)), cmft_pkg::ID_W'($urandom),
                cmft_pkg::RECORD_W'({$urandom, $urandom}),
                cmft_pkg::SLOT_W'($urandom_range(0, 15)));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      w.op = cmft_pkg::OP_FRAME; w.extended = 1'b0; w.remote = 1'b0;
      w.len = ($urandom_range(0, 9) == 0) ? cmft_pkg::LEN_W'($urandom_range(9, 15))
                                          : cmft_pkg::LEN_W'($urandom_range(7, 8));
      w.std_id = cmft_pkg::SLOT_ID_BASE + cmft_pkg::ID_W'($urandom_range(1, SLOTS - 1));
    end else if (pick < 57) begin
      w.op = cmft_pkg::OP_FRAME;
      if ($urandom_range(0, 1) == 1)
        w.std_id = cmft_pkg::ID_W'($urandom_range(11'h200, 11'h20f));
    end else if (pick < 82) begin
      w.op = cmft_pkg::OP_READ_SLOT;
      if ($urandom_range(0, 4) != 0) w.qslot = cmft_pkg::SLOT_W'($urandom_range(1, SLOTS - 1));
    end else if (pick < 95) begin
      w.op = cmft_pkg::OP_READ_LAST;
    end else begin
      w.op = OP_UNUSED;
    end
    return w;
  endfunction

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stimulus, reset and end of run
  initial begin
    // Directed: empty table, field extremes, every rejection reason, every operation
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_LAST, 0, 0, 4'd8, 11'h205, '0, 4'd1));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd8, 11'h205, '0, 4'd1));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd8, 11'h205, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd7, 11'h20b, '0, 4'd15));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd8, 11'h204, 56'h1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd8, 11'h20c, 56'h2, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd8, 11'h7ff, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd8, 11'h000, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 1, 0, 4'd8, 11'h206, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 1, 4'd8, 11'h206, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd6, 11'h206, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd0, 11'h206, '1, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd15, 11'h206,
                                    56'h8000_8000_8000_80, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_FRAME, 0, 0, 4'd9, 11'h207,
                                    56'h7fff_7fff_7fff_7f, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd0, 11'h0, '0, 4'd0));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd0, 11'h0, '0, 4'd1));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd0, 11'h0, '0, 4'd7));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd0, 11'h0, '0, 4'd8));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd0, 11'h0, '0, 4'd15));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 1, 1, 4'd15, 11'h7ff, '1, 4'd2));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_SLOT, 0, 0, 4'd0, 11'h0, '0, 4'd3));
    pending_words.push_back(mk_word(cmft_pkg::OP_READ_LAST, 1, 1, 4'd15, 11'h7ff, '1, 4'd15));
    pending_words.push_back(mk_word(OP_UNUSED, 0, 0, 4'd8, 11'h205, '1, 4'd1));
    pending_words.push_back(mk_word(OP_UNUSED, 1, 1, 4'd15, 11'h7ff, '0, 4'd0));
    for (int unsigned i = 0; i < N_RANDOM; i++) pending_words.push_back(random_word());
    total_words = pending_words.size();

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: all words sent and every result word back
    while (pending_words.size() != 0 || in_valid_i || expected_feedback.size() != 0)
      @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    $display("Summary: %0d words sent, %0d result words checked (%0d found), %0d errors.",
             words_in, results_seen, found_seen, failures);
    $display("Covered frames, slot and last reads, unused opcode, idle bursts");
    $display("and a %0d-cycle output hold.", LONG_HOLD);
    if (failures == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Driver: predict on acceptance, then offer the next word or idle
  always @(posedge clk_i) begin
    if (rst_ni && (!in_valid_i || !in_stall_o)) begin
      if (in_valid_i) begin
        expected_feedback.push_back(predict_feedback(cur_word));
        words_in <= words_in + 1;
      end
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (!quiet && pending_words.size() != 0 && $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 14);
        in_valid_i <= 1'b0;
      end else if (pending_words.size() != 0) begin
        cur_word = pending_words.pop_front();
        operation_i    <= cur_word.op;
        is_extended_i  <= cur_word.extended;
        is_remote_i    <= cur_word.remote;
        frame_length_i <= cur_word.len;
        std_id_i       <= cur_word.std_id;
        payload_i      <= cur_word.data;
        query_slot_i   <= cur_word.qslot;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver stall: random bursts plus one long hold to fill the block
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (!long_hold_done && results_seen >= 300) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_left <= $urandom_range(0, 14);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      failures++;
    end
  endtask

  // Monitor: compare each accepted result word with the oldest prediction
  always @(posedge clk_i) begin
    feedback_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen <= results_seen + 1;
      if (expected_feedback.size() == 0) begin
        $error("result word with no prediction pending");
        failures++;
      end else begin
        want = expected_feedback.pop_front();
        if (want.found) found_seen <= found_seen + 1;
        check_field("found", 64'(want.found), 64'(found_o));
        check_field("slot", 64'(want.slot), 64'(slot_o));
        check_field("angle", 64'(want.angle), 64'(angle_o));
        check_field("speed", 64'(unsigned'(want.speed)), 64'(unsigned'(speed_o)));
        check_field("current", 64'(unsigned'(want.current)), 64'(unsigned'(current_o)));
        check_field("temperature", 64'(want.temperature), 64'(temperature_o));
        check_field("source_id", 64'(want.source_id), 64'(source_id_o));
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("Timeout after %0d cycles with %0d predictions pending.",
               cycles, expected_feedback.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

endmodule

@@ files.f @@
hdl/cmft_pkg.sv
hdl/cmft_front.sv
hdl/cmft_queue.sv
hdl/cmft_back.sv
hdl/can_motor_feedback_table_unit.sv
verif/testbench.sv
